>>> hw/rtl/stt_pkg.sv
// Shared types and constants for the software timer slot table.
// Holds field widths, operation codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package stt_pkg;

   // Field widths
   localparam int SLOT_W      = 4;
   localparam int TIME_W      = 32;
   localparam int ELAPSED_W   = 16;
   localparam int GRAN_W      = 20;

   // Table depth default and register reset value
   localparam int NUM_SLOTS_DEF = 16;
   localparam logic [GRAN_W-1:0] GRAN_RESET = 20'd1000000;

   // Result kinds
   localparam logic KIND_FIRE  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Operation codes
   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_ARM    = 2'd1,
      FUNC_CANCEL = 2'd2,
      FUNC_QUERY  = 2'd3
   } func_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV,
      ST_ARMW,
      ST_QOP,
      ST_MUL,
      ST_TRD,
      ST_TUPD,
      ST_PUSH,
      ST_FINAL
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;       // latch the request word
      logic rd_slot;    // read table at the request slot
      logic rd_idx;     // read table at the walk index
      logic idx_clr;    // restart the walk
      logic idx_inc;    // advance the walk
      logic upd;        // apply tick to the slot just read
      logic div_start;  // clear divider
      logic div_step;   // one quotient bit
      logic arm_write;  // store the armed slot
      logic cancel;     // free the request slot
      logic q_oper;     // take query operands from the read data
      logic mul;        // scale operand to microseconds into the pending result
      logic push;       // pending result to output, not last
      logic push_last;  // pending result to output, last
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      func_type func;
      logic     in_table;
      logic     fire;
      logic     walk_done;
      logic     div_done;
      logic     out_free;
      logic     pend_valid;
   } dp_sts_type;

endpackage

>>> hw/rtl/stt_req_if.sv
// Request channel of the timer slot table: valid/ready plus one request word.
// Depends on stt_pkg for field widths.
interface stt_req_if
   import stt_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [1:0]           func;
   logic [SLOT_W-1:0]    slot;
   logic [TIME_W-1:0]    value_us;
   logic [TIME_W-1:0]    interval_us;
   logic [ELAPSED_W-1:0] elapsed_ticks;

   modport source (output valid, func, slot, value_us, interval_us, elapsed_ticks,
                   input ready);
   modport sink   (input valid, func, slot, value_us, interval_us, elapsed_ticks,
                   output ready);
endinterface

>>> hw/rtl/stt_rsp_if.sv
// Response channel of the timer slot table: valid/ready plus one result word.
// Depends on stt_pkg for field widths.
interface stt_rsp_if
   import stt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [SLOT_W-1:0] fired_slot;
   logic [TIME_W-1:0] remaining_us;
   logic              is_periodic;
   logic              is_active;
   logic              last;

   modport source (output valid, kind, fired_slot, remaining_us, is_periodic,
                   is_active, last, input ready);
   modport sink   (input valid, kind, fired_slot, remaining_us, is_periodic,
                   is_active, last, output ready);
endinterface

>>> hw/rtl/stt_datapath.sv
// Datapath of the timer slot table: slot memories, active flags, divider,
// multiplier, pending result and output register.
// Depends on stt_pkg and stt_rsp_if; driven by stt_controller commands.
module stt_datapath
   import stt_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [GRAN_W-1:0]    csr_wdata,
   input  logic [1:0]           req_func,
   input  logic [SLOT_W-1:0]    req_slot,
   input  logic [TIME_W-1:0]    req_value_us,
   input  logic [TIME_W-1:0]    req_interval_us,
   input  logic [ELAPSED_W-1:0] req_elapsed_ticks,
   input  dp_cmd_type           cmd,
   output dp_sts_type           sts,
   stt_rsp_if.source            rsp_ch
);

   localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW     = $clog2(NUM_SLOTS + 1);
   localparam int EW     = (SW > SLOT_W) ? SW : SLOT_W;
   localparam int PW     = TIME_W + GRAN_W;
   localparam int DCW    = $clog2(TIME_W + 1);
   localparam logic [CW-1:0]  WALK_END = CW'(NUM_SLOTS);
   localparam logic [DCW-1:0] DIV_END  = DCW'(TIME_W);

   // Granularity register
   logic [GRAN_W-1:0] gran_ff, gran_in;
   logic [GRAN_W-1:0] gran_eff;

   always_comb begin
      gran_in = csr_we ? csr_wdata : gran_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gran_ff <= GRAN_RESET;
      end else begin
         gran_ff <= gran_in;
      end
   end

   assign gran_eff = (gran_ff == '0) ? GRAN_W'(1) : gran_ff;

   // Request word latch; the divider shift register takes the dividend
   func_type             func_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic                 arm_per_ff;
   logic [TIME_W-1:0]    dq_ff, dq_in;
   logic [GRAN_W-1:0]    div_rem_ff, div_rem_in;
   logic [DCW-1:0]       div_cnt_ff, div_cnt_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= func_type'(req_func);
         slot_ff    <= req_slot;
         elapsed_ff <= req_elapsed_ticks;
         arm_per_ff <= (req_value_us == '0);
      end
   end

   // Restoring divider, one quotient bit per step
   logic [GRAN_W:0] trial;
   logic [GRAN_W:0] divisor_ext;
   logic            div_ge;

   always_comb begin
      trial       = {div_rem_ff, dq_ff[TIME_W-1]};
      divisor_ext = {1'b0, gran_eff};
      div_ge      = (trial >= divisor_ext);
      dq_in       = dq_ff;
      div_rem_in  = div_rem_ff;
      div_cnt_in  = div_cnt_ff;
      if (cmd.load) begin
         dq_in = (req_value_us == '0) ? req_interval_us : req_value_us;
      end else if (cmd.div_step) begin
         dq_in = {dq_ff[TIME_W-2:0], div_ge};
      end
      if (cmd.div_start) begin
         div_rem_in = '0;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         div_rem_in = div_ge ? GRAN_W'(trial - divisor_ext) : trial[GRAN_W-1:0];
         div_cnt_in = div_cnt_ff + DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      dq_ff      <= dq_in;
      div_rem_ff <= div_rem_in;
      div_cnt_ff <= div_cnt_in;
   end

   // Slot addressing
   logic [EW-1:0] slot_wide;
   logic [SW-1:0] slot_idx;
   logic          in_table;

   assign slot_wide = EW'(slot_ff);
   assign slot_idx  = slot_wide[SW-1:0];
   assign in_table  = (32'(slot_ff) < 32'(NUM_SLOTS));

   // Walk index
   logic [CW-1:0] idx_ff, idx_in;
   logic [SW-1:0] idx_a;
   logic [EW-1:0] idx_wide;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assign idx_a    = idx_ff[SW-1:0];
   assign idx_wide = EW'(idx_a);

   // Slot memories with registered read
   logic [TIME_W-1:0] rem_mem [NUM_SLOTS];
   logic [TIME_W-1:0] rel_mem [NUM_SLOTS];
   logic              per_mem [NUM_SLOTS];
   logic [TIME_W-1:0] rd_rem_ff, rd_rel_ff;
   logic              rd_per_ff;
   logic [SW-1:0]     raddr;

   assign raddr = cmd.rd_idx ? idx_a : slot_idx;

   always_ff @(posedge clock) begin
      if (cmd.rd_idx || cmd.rd_slot) begin
         rd_rem_ff <= rem_mem[raddr];
         rd_rel_ff <= rel_mem[raddr];
         rd_per_ff <= per_mem[raddr];
      end
   end

   // Tick update of the slot just read
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic                 act_i;
   logic                 fire;
   logic [TIME_W-1:0]    tick_rem;
   logic [TIME_W-1:0]    fire_rem;

   assign act_i    = active_ff[idx_a];
   assign fire     = act_i && (rd_rem_ff < TIME_W'(elapsed_ff));
   assign fire_rem = rd_per_ff ? rd_rel_ff : '0;
   assign tick_rem = fire ? fire_rem : (rd_rem_ff - TIME_W'(elapsed_ff));

   always_ff @(posedge clock) begin
      if (cmd.arm_write) begin
         rem_mem[slot_idx] <= dq_ff;
         rel_mem[slot_idx] <= dq_ff;
         per_mem[slot_idx] <= arm_per_ff;
      end else if (cmd.upd && act_i) begin
         rem_mem[idx_a] <= tick_rem;
      end
   end

   // Active flags
   always_comb begin
      active_in = active_ff;
      if (cmd.arm_write) begin
         active_in[slot_idx] = 1'b1;
      end
      if (cmd.cancel && in_table) begin
         active_in[slot_idx] = 1'b0;
      end
      if (cmd.upd && fire && !rd_per_ff) begin
         active_in[idx_a] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   // Result operands ahead of the multiplier
   logic              act_q;
   logic [TIME_W-1:0] oper_rem_ff;
   logic              oper_per_ff, oper_act_ff, oper_kind_ff;
   logic [SLOT_W-1:0] oper_slot_ff;

   assign act_q = in_table && active_ff[slot_idx];

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         oper_rem_ff  <= fire_rem;
         oper_per_ff  <= rd_per_ff;
         oper_act_ff  <= rd_per_ff;
         oper_kind_ff <= KIND_FIRE;
         oper_slot_ff <= idx_wide[SLOT_W-1:0];
      end else if (cmd.q_oper) begin
         oper_rem_ff  <= act_q ? rd_rem_ff : '0;
         oper_per_ff  <= act_q && rd_per_ff;
         oper_act_ff  <= act_q;
         oper_kind_ff <= KIND_QUERY;
         oper_slot_ff <= slot_ff;
      end
   end

   // Multiplier into the pending result, held back until the next fire or the final push
   logic [PW-1:0]     prod;
   logic [TIME_W-1:0] pend_rem_ff;
   logic              pend_per_ff, pend_act_ff, pend_kind_ff;
   logic [SLOT_W-1:0] pend_slot_ff;
   logic              pend_valid_ff, pend_valid_in;

   assign prod = PW'(oper_rem_ff) * PW'(gran_eff);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         pend_rem_ff  <= prod[TIME_W-1:0];
         pend_per_ff  <= oper_per_ff;
         pend_act_ff  <= oper_act_ff;
         pend_kind_ff <= oper_kind_ff;
         pend_slot_ff <= oper_slot_ff;
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.mul) begin
         pend_valid_in = 1'b1;
      end else if (cmd.push_last) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_per_ff, rsp_act_ff, rsp_last_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [TIME_W-1:0] rsp_rem_ff;
   logic              out_free;
   logic              out_load;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign out_load = cmd.push || cmd.push_last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_slot_ff <= pend_slot_ff;
         rsp_rem_ff  <= pend_rem_ff;
         rsp_per_ff  <= pend_per_ff;
         rsp_act_ff  <= pend_act_ff;
         rsp_last_ff <= cmd.push_last;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_kind_ff;
   assign rsp_ch.fired_slot   = rsp_slot_ff;
   assign rsp_ch.remaining_us = rsp_rem_ff;
   assign rsp_ch.is_periodic  = rsp_per_ff;
   assign rsp_ch.is_active    = rsp_act_ff;
   assign rsp_ch.last         = rsp_last_ff;

   // Status
   always_comb begin
      sts.func       = func_ff;
      sts.in_table   = in_table;
      sts.fire       = fire;
      sts.walk_done  = (idx_ff == WALK_END);
      sts.div_done   = (div_cnt_ff == DIV_END);
      sts.out_free   = out_free;
      sts.pend_valid = pend_valid_ff;
   end

endmodule

>>> hw/rtl/stt_controller.sv
// Controller of the timer slot table: one state machine that sequences
// arm division, tick walk, query and result delivery.
// Depends on stt_pkg; drives stt_datapath through dp_cmd_type.
module stt_controller
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (sts.func)
               FUNC_TICK:   state_in = ST_TRD;
               FUNC_ARM:    state_in = sts.in_table ? ST_DIV : ST_IDLE;
               FUNC_CANCEL: state_in = ST_IDLE;
               FUNC_QUERY:  state_in = ST_QOP;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_ARMW;
         end
         ST_ARMW: state_in = ST_IDLE;
         ST_QOP:  state_in = ST_MUL;
         ST_MUL: begin
            state_in = (sts.func == FUNC_QUERY) ? ST_FINAL : ST_TRD;
         end
         ST_TRD: begin
            if (sts.walk_done) begin
               state_in = sts.pend_valid ? ST_FINAL : ST_IDLE;
            end else begin
               state_in = ST_TUPD;
            end
         end
         ST_TUPD: begin
            if (sts.fire) begin
               state_in = sts.pend_valid ? ST_PUSH : ST_MUL;
            end else begin
               state_in = ST_TRD;
            end
         end
         ST_PUSH: begin
            if (sts.out_free) state_in = ST_MUL;
         end
         ST_FINAL: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DISPATCH: begin
            case (sts.func)
               FUNC_TICK:   cmd.idx_clr   = 1'b1;
               FUNC_ARM:    cmd.div_start = sts.in_table;
               FUNC_CANCEL: cmd.cancel    = 1'b1;
               FUNC_QUERY:  cmd.rd_slot   = 1'b1;
               default:     cmd.idx_clr   = 1'b0;
            endcase
         end
         ST_DIV:   cmd.div_step  = !sts.div_done;
         ST_ARMW:  cmd.arm_write = 1'b1;
         ST_QOP:   cmd.q_oper    = 1'b1;
         ST_MUL:   cmd.mul       = 1'b1;
         ST_TRD:   cmd.rd_idx    = !sts.walk_done;
         ST_TUPD: begin
            cmd.upd     = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         ST_PUSH:  cmd.push      = sts.out_free;
         ST_FINAL: cmd.push_last = sts.out_free;
         default:  cmd.load      = 1'b0;
      endcase
   end

endmodule

>>> hw/rtl/software_timer_slot_table_top.sv
// Top level of the software timer slot table.
// Depends on stt_pkg, stt_req_if, stt_rsp_if, stt_controller, stt_datapath.
//
// Usage: requests arrive on req_ch (valid/ready), one word per operation:
// tick, arm, cancel or query. Results leave on rsp_ch (valid/ready); a tick
// gives one word per fired slot in slot order, a query gives exactly one
// word, arm and cancel give none. The last word of an operation has last set.
// csr_we/csr_wdata write the granularity register; write it only when idle.
//
// One request is worked at a time; req_ch.ready is high only when idle.
// Arm: set by the one-bit-per-cycle divider (32 steps), then the slot write.
// Cancel: frees the slot in dispatch. Query: read, operands, multiply, result.
// Tick: a read and an update state per slot for the walk over NUM_SLOTS slots,
// plus a multiply and, if a result is pending, a push state per fired slot.
// Each fired result is held back one step so that last can be set; a
// receiver stall freezes the walk at the next result until the output
// register frees.
// Reset clears all slots to inactive and sets the granularity to 1000000.
module software_timer_slot_table_top
   import stt_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   stt_req_if.sink           req_ch,
   stt_rsp_if.source         rsp_ch,
   input  logic              csr_we,
   input  logic [GRAN_W-1:0] csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_ready;

   assign req_ch.ready = req_ready;

   // Sequencer
   stt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and arithmetic
   stt_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_func          (req_ch.func),
      .req_slot          (req_ch.slot),
      .req_value_us      (req_ch.value_us),
      .req_interval_us   (req_ch.interval_us),
      .req_elapsed_ticks (req_ch.elapsed_ticks),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ch            (rsp_ch)
   );

endmodule
